/* sv/salru_pkg.sv */
// ----------------------------------------------------------------------------
// salru_pkg
// shared constants, codes and control types of the set-associative lru cache
// simulator
// ----------------------------------------------------------------------------
package salru_pkg;

  // defaults of the top-level parameters
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  // access kinds
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  // register word indexes on the config port
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  // config port address width
  localparam int CFG_AW = 4;

  // register reset values
  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways;
    logic [5:0] block_bits;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC1,
    ST_ACC2
  } st_t;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the input item
    logic rd;      // read the set row
    logic acc1;    // first access pass
    logic acc2;    // second pass of a modify
    logic finish;  // write the row back for a valid op and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_modify;
    logic out_free;
  } sts_t;

endpackage

/* sv/salru_ram.sv */
// ----------------------------------------------------------------------------
// salru_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/salru_regs.sv */
// ----------------------------------------------------------------------------
// salru_regs
// apb-style configuration registers: set bits, ways, block bits
// ----------------------------------------------------------------------------
module salru_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [salru_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output salru_pkg::cfg_t                cfg
);

  logic [2:0] set_bits_r;
  logic [3:0] ways_r;
  logic [5:0] block_bits_r;
  logic       wr;

  // pready is tied high, so the access phase always completes
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= salru_pkg::SET_BITS_RST;
      ways_r       <= salru_pkg::WAYS_RST;
      block_bits_r <= salru_pkg::BLOCK_BITS_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        salru_pkg::REG_SET_BITS:   set_bits_r   <= pwdata[2:0];
        salru_pkg::REG_WAYS:       ways_r       <= pwdata[3:0];
        salru_pkg::REG_BLOCK_BITS: block_bits_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      salru_pkg::REG_SET_BITS:   prdata = {29'd0, set_bits_r};
      salru_pkg::REG_WAYS:       prdata = {28'd0, ways_r};
      salru_pkg::REG_BLOCK_BITS: prdata = {26'd0, block_bits_r};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg.set_bits   = set_bits_r;
  assign cfg.ways       = ways_r;
  assign cfg.block_bits = block_bits_r;

endmodule

/* sv/salru_ctrl.sv */
// ----------------------------------------------------------------------------
// salru_ctrl
// sequencer: accept, read set row, one or two access passes, write back
// ----------------------------------------------------------------------------
module salru_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  salru_pkg::sts_t   sts,
  output salru_pkg::cmd_t   cmd
);

  salru_pkg::st_t state_r;
  salru_pkg::st_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salru_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      salru_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = salru_pkg::ST_READ;
        end
      end
      salru_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = salru_pkg::ST_ACC1;
      end
      salru_pkg::ST_ACC1: begin
        if (sts.is_modify) begin
          cmd.acc1  = 1'b1;
          state_nxt = salru_pkg::ST_ACC2;
        end else if (sts.out_free) begin
          cmd.acc1   = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = salru_pkg::ST_IDLE;
        end
      end
      salru_pkg::ST_ACC2: begin
        if (sts.out_free) begin
          cmd.acc2   = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = salru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = salru_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/salru_dp.sv */
// ----------------------------------------------------------------------------
// salru_dp
// datapath: address split, set row ram, tag match, lru reorder, counters,
// result register
// ----------------------------------------------------------------------------
module salru_dp #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salru_pkg::ADDR_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  salru_pkg::cfg_t        cfg,
  input  salru_pkg::cmd_t        cmd,
  output salru_pkg::sts_t        sts,
  input  logic [1:0]             in_op,
  input  logic [ADDR_WIDTH-1:0]  in_addr,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   out_hit,
  output logic                   out_miss,
  output logic                   out_eviction,
  output logic                   out_second_hit,
  output logic [31:0]            out_hit_count,
  output logic [31:0]            out_miss_count,
  output logic [31:0]            out_eviction_count
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_PAD  = 1 << WAY_W;
  localparam int NW_W     = $clog2(MAX_WAYS + 1);
  localparam int ROW_W    = MAX_WAYS * (ADDR_WIDTH + 1 + WAY_W);

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == '1) ? c : c + 32'd1;
  endfunction

  // captured item
  logic [1:0]            op_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic                  op_ok;

  // address split
  logic [2:0]            sb;
  logic [6:0]            tag_sh;
  logic [ADDR_WIDTH-1:0] addr_blk;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_comb;
  logic [ADDR_WIDTH-1:0] tag_comb;
  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [NW_W-1:0]       nways;
  logic [WAY_W-1:0]      last;

  // rows that have been written at least once
  logic [NUM_SETS-1:0]   row_ok_r;

  // ram port
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      ram_wdata;
  logic                  ram_wr;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] ram_tag, row_tag_r, src_tag, new_tag;
  logic [MAX_WAYS-1:0]                 ram_vld, row_vld_r, src_vld, new_vld;
  logic [MAX_WAYS-1:0][WAY_W-1:0]      ram_ord, row_ord_r, src_ord, new_ord;

  logic [WAY_PAD-1:0]    match_pad;
  logic [WAY_PAD-1:0]    vld_pad;
  logic                  hit;
  logic [WAY_W-1:0]      pos;
  logic [WAY_W-1:0]      victim;
  logic                  evict;

  // totals and pass flags
  logic [31:0] hit_cnt_r, miss_cnt_r, ev_cnt_r;
  logic [31:0] hit_cnt_nxt, miss_cnt_nxt, ev_cnt_nxt;
  logic        hit_inc, miss_inc, ev_inc;
  logic        flag_hit_r, flag_ev_r;

  // result register
  logic        out_valid_r;
  logic        out_hit_r, out_miss_r, out_ev_r, out_second_r;
  logic [31:0] out_hit_cnt_r, out_miss_cnt_r, out_ev_cnt_r;

  assign op_ok = (op_r == salru_pkg::OP_LOAD) || (op_r == salru_pkg::OP_STORE) ||
                 (op_r == salru_pkg::OP_MODIFY);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      addr_r <= in_addr;
    end
    if (cmd.rd) begin
      set_r <= set_comb;
      tag_r <= tag_comb;
    end
  end

  // set bits saturate at the build maximum
  assign sb       = (int'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
  assign tag_sh   = {1'b0, cfg.block_bits} + {4'd0, sb};
  assign addr_blk = addr_r >> cfg.block_bits;
  assign set_mask = ~({SET_W{1'b1}} << sb);
  assign set_comb = addr_blk[SET_W-1:0] & set_mask;
  assign tag_comb = addr_r >> tag_sh;

  always_comb begin
    if (cfg.ways == 4'd0) begin
      nways = NW_W'(1);
    end else if (int'(cfg.ways) > MAX_WAYS) begin
      nways = NW_W'(MAX_WAYS);
    end else begin
      nways = NW_W'(cfg.ways);
    end
  end

  assign last = WAY_W'(nways - NW_W'(1));

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (set_r),
    .wr_data (ram_wdata),
    .rd_en   (cmd.rd),
    .rd_addr (set_comb),
    .rd_data (ram_rdata)
  );

  assign {ram_tag, ram_vld, ram_ord} = ram_rdata;

  // working row: held row on the second pass, reset row if never written
  always_comb begin
    if (cmd.acc2) begin
      src_tag = row_tag_r;
      src_vld = row_vld_r;
      src_ord = row_ord_r;
    end else if (row_ok_r[set_r]) begin
      src_tag = ram_tag;
      src_vld = ram_vld;
      src_ord = ram_ord;
    end else begin
      src_tag = '0;
      src_vld = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
        src_ord[w] = WAY_W'(w);
      end
    end
  end

  // tag match and first matching recency position
  always_comb begin
    match_pad = '0;
    vld_pad   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld_pad[w]   = src_vld[w];
      match_pad[w] = src_vld[w] && (src_tag[w] == tag_r);
    end
    hit = 1'b0;
    pos = '0;
    for (int p = MAX_WAYS - 1; p >= 0; p--) begin
      if ((NW_W'(p) < nways) && match_pad[src_ord[p]]) begin
        hit = 1'b1;
        pos = WAY_W'(p);
      end
    end
  end

  assign victim = src_ord[0];
  assign evict  = !hit && vld_pad[victim];

  // move position pos to the most recent in-use slot, refill on a miss
  always_comb begin
    new_tag = src_tag;
    new_vld = src_vld;
    for (int j = 0; j < MAX_WAYS; j++) begin
      new_ord[j] = src_ord[j];
      if (WAY_W'(j) < pos) begin
        new_ord[j] = src_ord[j];
      end else if (WAY_W'(j) < last) begin
        if (j < MAX_WAYS - 1) begin
          new_ord[j] = src_ord[j + 1];
        end
      end else if (WAY_W'(j) == last) begin
        new_ord[j] = src_ord[pos];
      end
    end
    if (!hit) begin
      new_vld[victim] = 1'b1;
      new_tag[victim] = tag_r;
    end
  end

  assign ram_wdata = {new_tag, new_vld, new_ord};
  assign ram_wr    = cmd.finish && op_ok;

  always_ff @(posedge clk) begin
    if (cmd.acc1) begin
      row_tag_r <= new_tag;
      row_vld_r <= new_vld;
      row_ord_r <= new_ord;
      flag_hit_r <= op_ok && hit;
      flag_ev_r  <= op_ok && evict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
    end else if (ram_wr) begin
      row_ok_r[set_r] <= 1'b1;
    end
  end

  // saturating totals; the store half of a modify always hits
  assign hit_inc  = (cmd.acc1 && op_ok && hit) || cmd.acc2;
  assign miss_inc = cmd.acc1 && op_ok && !hit;
  assign ev_inc   = miss_inc && evict;

  assign hit_cnt_nxt  = hit_inc  ? sat_inc(hit_cnt_r)  : hit_cnt_r;
  assign miss_cnt_nxt = miss_inc ? sat_inc(miss_cnt_r) : miss_cnt_r;
  assign ev_cnt_nxt   = ev_inc   ? sat_inc(ev_cnt_r)   : ev_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      ev_cnt_r   <= '0;
    end else begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      ev_cnt_r   <= ev_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd.acc2) begin
        out_hit_r    <= flag_hit_r;
        out_miss_r   <= !flag_hit_r;
        out_ev_r     <= flag_ev_r;
        out_second_r <= 1'b1;
      end else begin
        out_hit_r    <= op_ok && hit;
        out_miss_r   <= op_ok && !hit;
        out_ev_r     <= op_ok && evict;
        out_second_r <= 1'b0;
      end
      out_hit_cnt_r  <= hit_cnt_nxt;
      out_miss_cnt_r <= miss_cnt_nxt;
      out_ev_cnt_r   <= ev_cnt_nxt;
    end
  end

  assign sts.is_modify = (op_r == salru_pkg::OP_MODIFY);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_miss           = out_miss_r;
  assign out_eviction       = out_ev_r;
  assign out_second_hit     = out_second_r;
  assign out_hit_count      = out_hit_cnt_r;
  assign out_miss_count     = out_miss_cnt_r;
  assign out_eviction_count = out_ev_cnt_r;

endmodule

/* sv/set_assoc_lru_cache_sim_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core
// set-associative cache simulator with lru replacement and hit, miss and
// eviction totals
// the result is registered in the final access pass, after the ram read of the
//   set row (load, store, unused op) or after a second pass (modify)
// one item at a time: a new item is taken only once the previous one is done,
//   each needing the ram read of the set row and, for a valid op, its write back, modify adding a second pass
// reset: synchronous; clears control, totals and per-set row flags at once,
//   no clearing pass, the ram content itself is never cleared
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salru_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [ADDR_WIDTH-1:0]         in_addr,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic                          out_miss,
  output logic                          out_eviction,
  output logic                          out_second_hit,
  output logic [31:0]                   out_hit_count,
  output logic [31:0]                   out_miss_count,
  output logic [31:0]                   out_eviction_count,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [salru_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // the config registers feed the datapath directly; the user must see that they are only
  // written while no item is in flight, as nothing in the block enforces this
  salru_pkg::cfg_t cfg;
  // command and status between sequencer and datapath
  salru_pkg::cmd_t cmd;
  salru_pkg::sts_t sts;

  // apb access always completes in its access cycle
  assign cfg_pready = 1'b1;

  salru_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // sequencer: idle -> read -> access (-> second access for modify) -> idle;
  // the final access waits there while the result register is full and stalled
  salru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: one ram row per set holds all tags, valid bits and the
  // recency order; a row never written reads as empty with ways in order
  salru_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_addr            (in_addr),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_miss           (out_miss),
    .out_eviction       (out_eviction),
    .out_second_hit     (out_second_hit),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count)
  );

endmodule

/* sv/salru_chk.sv */
// ----------------------------------------------------------------------------
// salru_chk
// port-level checks of the cache simulator, bound to the top level
// ----------------------------------------------------------------------------
module salru_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic        out_miss,
  input logic        out_eviction,
  input logic        out_second_hit,
  input logic [31:0] out_hit_count,
  input logic [31:0] out_miss_count,
  input logic [31:0] out_eviction_count
);

  // a stalled item stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_hit, out_miss, out_eviction,
      out_second_hit, out_hit_count, out_miss_count, out_eviction_count}))
    else $error("result changed while stalled");

  // first access is never both a hit and a miss; an eviction only on a miss
  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_miss) && (!out_eviction || out_miss))
    else $error("inconsistent hit, miss and eviction flags");

  // a second pass only follows a real first access
  a_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_hit |-> out_hit || out_miss)
    else $error("second hit without a first access");

  // one item at a time: busy right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while the previous one is in flight");

endmodule

bind set_assoc_lru_cache_sim_core salru_chk u_chk (.*);
